[hw/rtl/imh_pkg.sv]
`default_nettype none
package imh_pkg;
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_DEC     = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_ABSENT    = 2'd2;
  localparam logic [1:0] ST_NOT_LOWER = 2'd3;

  localparam int OP_W     = 2;
  localparam int VTX_W    = 10;
  localparam int KEY_W    = 31;
  localparam int TOTAL_W  = 11;
  localparam int STATUS_W = 2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VTX_W-1:0]   vertex;
    logic [KEY_W-1:0]   new_key;
    logic [TOTAL_W-1:0] vertex_total;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VTX_W-1:0]    out_vertex;
    logic [KEY_W-1:0]    out_key;
    logic                in_heap;
    logic [TOTAL_W-1:0]  heap_count;
  } rsp_t;
endpackage
`default_nettype wire

[hw/rtl/imh_stream_if.sv]
`default_nettype none
interface imh_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/indexed_min_heap_decrease_key.sv]
// Operations: load writes one slot per cycle (up to 1024 slots); query; decrease-key
// moves the entry up level by level, and answers early when the key is not lower or
// when the heap is empty or the vertex absent; extract moves the last entry down
// level by level, and answers early when empty. One beat at a time: the next beat is
// taken only after the result beat leaves. Synchronous active-high reset clears
// size, load count and control; memories are not cleared (reads are guarded).
`default_nettype none
module indexed_min_heap_decrease_key (
  input wire clk,
  input wire rst,
  imh_stream_if.sink   req,
  imh_stream_if.source rsp
);
  localparam int VW = imh_pkg::VTX_W;
  localparam int KW = imh_pkg::KEY_W;
  localparam int NW = imh_pkg::TOTAL_W;
  localparam logic [NW-1:0] MAXV = NW'(1024);
  localparam logic [KW-1:0] INF = '1;

  localparam logic [3:0] S_IDLE = 4'd0, S_LOAD = 4'd1, S_DEC0 = 4'd2, S_DEC1 = 4'd3,
    S_UPRD = 4'd4, S_UPCMP = 4'd5, S_EX0 = 4'd6, S_EX1 = 4'd7, S_DNL = 4'd8,
    S_DNR = 4'd9, S_DNCMP = 4'd10, S_Q0 = 4'd11, S_Q1 = 4'd12, S_DONE = 4'd13,
    S_DNR2 = 4'd14, S_SWAP = 4'd15;

  logic [VW-1:0] slot_vertex [1024];
  logic [KW-1:0] slot_key [1024];
  logic [VW-1:0] vertex_slot [1024];

  logic [3:0] state;
  logic [NW-1:0] heap_size, loaded_total, cnt;
  imh_pkg::req_t r;
  imh_pkg::rsp_t out;
  logic out_valid;

  // registered memory reads
  logic [VW-1:0] rd_sv, rd_vs;
  logic [KW-1:0] rd_sk;
  logic [VW-1:0] ra_s, ra_v;

  // walking entry
  logic [VW-1:0] cur_v;
  logic [KW-1:0] cur_k;
  logic [NW-1:0] idx, best;
  logic [VW-1:0] best_v;
  logic [KW-1:0] best_k;
  logic [NW-1:0] child;

  // single write port per memory
  logic we_s, we_p;
  logic [VW-1:0] wa_s, wd_sv, wa_p, wd_p;
  logic [KW-1:0] wd_sk;

  always_ff @(posedge clk) begin
    if (we_s) begin
      slot_vertex[wa_s] <= wd_sv;
      slot_key[wa_s] <= wd_sk;
    end
    if (we_p) vertex_slot[wa_p] <= wd_p;
    rd_sv <= slot_vertex[ra_s];
    rd_sk <= slot_key[ra_s];
    rd_vs <= vertex_slot[ra_v];
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out;

  logic [NW-1:0] parent;
  assign parent = (idx - NW'(1)) >> 1;

  always_comb begin
    ra_s = '0; ra_v = r.vertex;
    we_s = 1'b0; we_p = 1'b0;
    wa_s = '0; wd_sv = '0; wd_sk = '0; wa_p = '0; wd_p = '0;
    unique case (state)
      S_LOAD: begin
        we_s = 1'b1; we_p = 1'b1;
        wa_s = cnt[VW-1:0]; wd_sv = cnt[VW-1:0]; wd_sk = INF;
        wa_p = cnt[VW-1:0]; wd_p = cnt[VW-1:0];
      end
      S_DEC1: ra_s = rd_vs;
      S_UPRD: ra_s = parent[VW-1:0];
      S_UPCMP: begin
        we_s = 1'b1; we_p = 1'b1; wa_s = idx[VW-1:0];
        if (idx != '0 && cur_k < rd_sk) begin
          wd_sv = rd_sv; wd_sk = rd_sk; wa_p = rd_sv;
        end else begin
          wd_sv = cur_v; wd_sk = cur_k; wa_p = cur_v;
        end
        wd_p = idx[VW-1:0];
      end
      S_EX0: ra_s = '0;
      S_EX1: ra_s = VW'(heap_size - NW'(1));
      S_DNL: ra_s = child[VW-1:0];
      S_DNR: ra_s = VW'(child + NW'(1));
      S_SWAP: begin
        we_s = 1'b1; we_p = 1'b1;
        wa_s = idx[VW-1:0]; wd_sv = best_v; wd_sk = best_k;
        wa_p = best_v; wd_p = idx[VW-1:0];
      end
      S_DNCMP: begin
        we_s = 1'b1; we_p = 1'b1;
        wa_s = idx[VW-1:0]; wd_sv = cur_v; wd_sk = cur_k;
        wa_p = cur_v; wd_p = idx[VW-1:0];
      end
      S_DONE: begin
        if (r.op == imh_pkg::OP_EXTRACT && out.status == imh_pkg::ST_OK) begin
          we_p = 1'b1; wa_p = out.out_vertex; wd_p = VW'(heap_size);
          we_s = heap_size != MAXV; wa_s = VW'(heap_size);
          wd_sv = out.out_vertex; wd_sk = out.out_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap_size <= '0; loaded_total <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && !out_valid) begin
          r <= req.data;
          out <= '0;
          cnt <= '0;
          unique case (req.data.op)
            imh_pkg::OP_LOAD: state <= (req.data.vertex_total == '0) ? S_DONE : S_LOAD;
            imh_pkg::OP_DEC: state <= S_DEC0;
            imh_pkg::OP_EXTRACT: state <= S_EX0;
            default: state <= S_Q0;
          endcase
          if (req.data.op == imh_pkg::OP_LOAD) begin
            heap_size <= (req.data.vertex_total > MAXV) ? MAXV : req.data.vertex_total;
            loaded_total <= (req.data.vertex_total > MAXV) ? MAXV : req.data.vertex_total;
          end
        end
        S_LOAD: begin
          cnt <= cnt + NW'(1);
          if (cnt + NW'(1) >= heap_size) state <= S_DONE;
        end
        S_DEC0: state <= S_DEC1;
        S_DEC1: begin
          if (heap_size == '0) begin
            out.status <= imh_pkg::ST_EMPTY; state <= S_DONE;
          end else if (NW'(r.vertex) >= loaded_total || NW'(rd_vs) >= heap_size) begin
            out.status <= imh_pkg::ST_ABSENT; state <= S_DONE;
          end else begin
            idx <= NW'(rd_vs); cur_v <= r.vertex; cur_k <= r.new_key;
            state <= S_UPRD;
            cnt <= '1;
          end
        end
        S_UPRD: begin
          // first pass checks the current key at the entry's slot
          if (cnt == '1) begin
            if (!(r.new_key < rd_sk)) begin
              out.status <= imh_pkg::ST_NOT_LOWER; state <= S_DONE;
            end else begin
              cnt <= '0; state <= S_UPRD;
            end
          end else state <= S_UPCMP;
        end
        S_UPCMP: begin
          if (idx != '0 && cur_k < rd_sk) begin
            idx <= parent; state <= S_UPRD;
          end else state <= S_DONE;
        end
        S_EX0: begin
          if (heap_size == '0) begin
            out.status <= imh_pkg::ST_EMPTY; state <= S_DONE;
          end else state <= S_EX1;
        end
        S_EX1: begin
          out.out_vertex <= rd_sv; out.out_key <= rd_sk;
          state <= S_DNL;
          idx <= '0; child <= NW'(1);
          cnt <= '1;
        end
        S_DNL: begin
          if (cnt == '1) begin
            cur_v <= rd_sv; cur_k <= rd_sk;
            heap_size <= heap_size - NW'(1);
            cnt <= '0;
            state <= S_DNL;
          end else state <= S_DNR;
        end
        S_DNR: begin
          if (child < heap_size && rd_sk < cur_k) begin
            best <= child; best_v <= rd_sv; best_k <= rd_sk;
          end else begin
            best <= idx; best_v <= cur_v; best_k <= cur_k;
          end
          state <= S_DNR2;
        end
        S_DNR2: begin
          if (child + NW'(1) < heap_size && rd_sk < best_k) begin
            best <= child + NW'(1); best_v <= rd_sv; best_k <= rd_sk;
          end
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (best == idx) state <= S_DONE;
          else state <= S_SWAP;
        end
        S_SWAP: begin
          idx <= best; child <= (best << 1) + NW'(1);
          state <= S_DNL;
        end
        S_Q0: state <= S_Q1;
        S_Q1: begin
          out.in_heap <= NW'(r.vertex) < loaded_total && NW'(rd_vs) < heap_size;
          state <= S_DONE;
        end
        S_DONE: begin
          out.heap_count <= heap_size;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) heap_size <= loaded_total)
    else $error("size above load count");
  assert property (@(posedge clk) disable iff (rst) loaded_total <= MAXV)
    else $error("load count too big");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_IDLE)
    else $error("busy while result pending");
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid && state == S_IDLE)
    else $error("result not posted");
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
  localparam logic [imh_pkg::KEY_W-1:0] KEY_INF = '1;
  localparam int MAX_V = 1024;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #10 clk = ~clk;

  imh_stream_if #(.T(imh_pkg::req_t)) req ();
  imh_stream_if #(.T(imh_pkg::rsp_t)) rsp ();

  indexed_min_heap_decrease_key DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // predictor state
  logic [imh_pkg::VTX_W-1:0] pq_vertex [MAX_V];
  logic [imh_pkg::KEY_W-1:0] pq_key    [MAX_V];
  logic [imh_pkg::VTX_W-1:0] pq_slot   [MAX_V];
  int unsigned pq_size;
  int unsigned pq_loaded;

  imh_pkg::rsp_t expected_rsps [$];
  int errors = 0;
  int idle_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void pq_place(int unsigned s, logic [imh_pkg::VTX_W-1:0] v,
                                   logic [imh_pkg::KEY_W-1:0] k);
    pq_vertex[s] = v;
    pq_key[s] = k;
    pq_slot[v] = s[imh_pkg::VTX_W-1:0];
  endfunction

  function automatic imh_pkg::rsp_t heap_apply(imh_pkg::req_t r);
    imh_pkg::rsp_t o;
    int unsigned i, p, best, l, rr, s, n, last;
    logic [imh_pkg::VTX_W-1:0] v;
    logic [imh_pkg::KEY_W-1:0] k;
    o = '0;
    case (r.op)
      imh_pkg::OP_LOAD: begin
        n = (32'(r.vertex_total) > MAX_V) ? MAX_V : 32'(r.vertex_total);
        for (i = 0; i < n; i++) pq_place(i, i[imh_pkg::VTX_W-1:0], KEY_INF);
        pq_size = n;
        pq_loaded = n;
      end
      imh_pkg::OP_DEC: begin
        if (pq_size == 0) o.status = imh_pkg::ST_EMPTY;
        else if (r.vertex >= pq_loaded || pq_slot[r.vertex] >= pq_size)
          o.status = imh_pkg::ST_ABSENT;
        else begin
          s = 32'(pq_slot[r.vertex]);
          if (!(r.new_key < pq_key[s])) o.status = imh_pkg::ST_NOT_LOWER;
          else begin
            v = pq_vertex[s];
            k = r.new_key;
            i = s;
            while (i > 0) begin
              p = (i - 1) / 2;
              if (!(k < pq_key[p])) break;
              pq_place(i, pq_vertex[p], pq_key[p]);
              i = p;
            end
            pq_place(i, v, k);
          end
        end
      end
      imh_pkg::OP_EXTRACT: begin
        if (pq_size == 0) o.status = imh_pkg::ST_EMPTY;
        else begin
          o.out_vertex = pq_vertex[0];
          o.out_key = pq_key[0];
          last = pq_size - 1;
          pq_place(0, pq_vertex[last], pq_key[last]);
          pq_size = last;
          pq_vertex[last] = o.out_vertex;
          pq_key[last] = o.out_key;
          pq_slot[o.out_vertex] = last[imh_pkg::VTX_W-1:0];
          i = 0;
          forever begin
            best = i;
            l = 2 * i + 1;
            rr = 2 * i + 2;
            if (l < pq_size && pq_key[l] < pq_key[best]) best = l;
            if (rr < pq_size && pq_key[rr] < pq_key[best]) best = rr;
            if (best == i) break;
            v = pq_vertex[i];
            k = pq_key[i];
            pq_place(i, pq_vertex[best], pq_key[best]);
            pq_place(best, v, k);
            i = best;
          end
        end
      end
      default: begin
        if (r.vertex < pq_loaded && pq_slot[r.vertex] < pq_size) o.in_heap = 1'b1;
      end
    endcase
    o.heap_count = pq_size[imh_pkg::TOTAL_W-1:0];
    return o;
  endfunction

  // response side: random stall and compare
  always @(posedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    imh_pkg::rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        report("unexpected beat", 32'(rsp.data.status), 32'd0);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.data.status !== want.status)
          report("status", 32'(rsp.data.status), 32'(want.status));
        if (rsp.data.out_vertex !== want.out_vertex)
          report("out_vertex", 32'(rsp.data.out_vertex), 32'(want.out_vertex));
        if (rsp.data.out_key !== want.out_key)
          report("out_key", 32'(rsp.data.out_key), 32'(want.out_key));
        if (rsp.data.in_heap !== want.in_heap)
          report("in_heap", 32'(rsp.data.in_heap), 32'(want.in_heap));
        if (rsp.data.heap_count !== want.heap_count)
          report("heap_count", 32'(rsp.data.heap_count), 32'(want.heap_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one beat; prediction happens when the beat is accepted
  task automatic send(input imh_pkg::req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    expected_rsps.push_back(heap_apply(r));
  endtask

  // check a directed beat against a typed-in result as well
  task automatic send_known(input imh_pkg::req_t r, input imh_pkg::rsp_t want);
    imh_pkg::rsp_t pred;
    send(r);
    pred = expected_rsps[$];
    if (pred !== want) report("directed row", 32'(pred.status), 32'(want.status));
  endtask

  function automatic imh_pkg::req_t mk(logic [1:0] op, int v,
                                       logic [imh_pkg::KEY_W-1:0] k, int n);
    imh_pkg::req_t r;
    r.op = op;
    r.vertex = v[imh_pkg::VTX_W-1:0];
    r.new_key = k;
    r.vertex_total = n[imh_pkg::TOTAL_W-1:0];
    return r;
  endfunction

  function automatic imh_pkg::rsp_t mr(logic [1:0] st, int v,
                                       logic [imh_pkg::KEY_W-1:0] k, bit h, int c);
    imh_pkg::rsp_t o;
    o.status = st;
    o.out_vertex = v[imh_pkg::VTX_W-1:0];
    o.out_key = k;
    o.in_heap = h;
    o.heap_count = c[imh_pkg::TOTAL_W-1:0];
    return o;
  endfunction

  typedef struct {
    imh_pkg::req_t r;
    bit            known;
    imh_pkg::rsp_t want;
  } row_t;

  function automatic imh_pkg::req_t rand_beat(int n);
    int sel;
    logic [imh_pkg::KEY_W-1:0] k;
    sel = $urandom_range(99);
    k = ($urandom_range(3) == 0) ? imh_pkg::KEY_W'($urandom)
                                 : imh_pkg::KEY_W'($urandom_range(1000));
    if (sel < 2) return mk(imh_pkg::OP_LOAD, $urandom, k, $urandom_range(40, 1));
    if (sel < 50)
      return mk(imh_pkg::OP_DEC, ($urandom_range(9) == 0) ? $urandom : $urandom_range(n),
                k, $urandom);
    if (sel < 80)
      return mk(imh_pkg::OP_EXTRACT, $urandom, imh_pkg::KEY_W'($urandom), $urandom);
    return mk(imh_pkg::OP_QUERY, ($urandom_range(7) == 0) ? $urandom : $urandom_range(n),
              imh_pkg::KEY_W'($urandom), $urandom);
  endfunction

  initial begin
    row_t rows [$];
    imh_pkg::req_t r;
    int n;
    req.valid = 1'b0;
    req.data = '0;
    pq_size = 0;
    pq_loaded = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1,
                     mr(imh_pkg::ST_EMPTY, 0, 0, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 0, 5, 0), 1, mr(imh_pkg::ST_EMPTY, 0, 0, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_QUERY, 1023, 0, 0), 1, mr(imh_pkg::ST_OK, 0, 0, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_LOAD, 0, 0, 0), 1, mr(imh_pkg::ST_OK, 0, 0, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_LOAD, 0, 0, 2047), 1,
                     mr(imh_pkg::ST_OK, 0, 0, 0, 1024)});
    rows.push_back('{mk(imh_pkg::OP_QUERY, 1023, 0, 0), 1,
                     mr(imh_pkg::ST_OK, 0, 0, 1, 1024)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 1023, KEY_INF, 0), 1,
                     mr(imh_pkg::ST_NOT_LOWER, 0, 0, 0, 1024)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 1023, 0, 0), 0, '0});
    rows.push_back('{mk(imh_pkg::OP_DEC, 512, 0, 0), 0, '0}); // tie with root: stays below
    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1,
                     mr(imh_pkg::ST_OK, 1023, 0, 0, 1023)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 1023, 0, 0), 1,
                     mr(imh_pkg::ST_ABSENT, 0, 0, 0, 1023)});
    rows.push_back('{mk(imh_pkg::OP_QUERY, 1023, 0, 0), 1,
                     mr(imh_pkg::ST_OK, 0, 0, 0, 1023)});
    rows.push_back('{mk(imh_pkg::OP_LOAD, 0, 0, 1024), 1,
                     mr(imh_pkg::ST_OK, 0, 0, 0, 1024)});
    rows.push_back('{mk(imh_pkg::OP_LOAD, 0, 0, 3), 1, mr(imh_pkg::ST_OK, 0, 0, 0, 3)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 5, 1, 0), 1, mr(imh_pkg::ST_ABSENT, 0, 0, 0, 3)});
    rows.push_back('{mk(imh_pkg::OP_QUERY, 5, 0, 0), 1, mr(imh_pkg::ST_OK, 0, 0, 0, 3)});
    rows.push_back('{mk(imh_pkg::OP_DEC, 2, KEY_INF - 1'b1, 0), 0, '0});
    rows.push_back('{mk(imh_pkg::OP_DEC, 1, 7, 0), 0, '0});
    rows.push_back('{mk(imh_pkg::OP_DEC, 1, 7, 0), 1,
                     mr(imh_pkg::ST_NOT_LOWER, 0, 0, 0, 3)});
    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1, mr(imh_pkg::ST_OK, 1, 7, 0, 2)});
    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1,
                     mr(imh_pkg::ST_OK, 2, KEY_INF - 1'b1, 0, 1)});
    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1,
                     mr(imh_pkg::ST_OK, 0, KEY_INF, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_EXTRACT, 0, 0, 0), 1,
                     mr(imh_pkg::ST_EMPTY, 0, 0, 0, 0)});
    rows.push_back('{mk(imh_pkg::OP_QUERY, 0, 0, 0), 1, mr(imh_pkg::ST_OK, 0, 0, 0, 0)});

    src_idle_pct = 33;
    snk_idle_pct = 48;
    foreach (rows[i]) begin
      if (rows[i].known) send_known(rows[i].r, rows[i].want);
      else send(rows[i].r);
    end

    // random part: mostly small loads followed by decreases, extracts and queries
    n = 1;
    for (int i = 0; i < 1950; i++) begin
      if (i == 650) begin
        src_idle_pct = 48;
        snk_idle_pct = 33;
      end
      if (i == 1300) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i == 0 || pq_size == 0 || $urandom_range(99) < 2) begin
        n = ($urandom_range(30) == 0) ? $urandom_range(1024, 900) : $urandom_range(40, 1);
        r = mk(imh_pkg::OP_LOAD, $urandom, imh_pkg::KEY_W'($urandom), n);
      end else if (i % 97 == 0) begin
        r = mk(imh_pkg::OP_DEC, $urandom_range(n - 1), imh_pkg::KEY_W'($urandom_range(2)), 0);
      end else begin
        r = rand_beat(n - 1);
      end
      send(r);
    end
    req.valid <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
